/* hdl/cmct_pkg.sv */
// shared types and constants for the coarse compare timer
`default_nettype none

package cmct_pkg;

    // field widths
    localparam int OPCODE_W  = 3;
    localparam int CHANNEL_W = 2;
    localparam int VALUE_W   = 32;
    localparam int MASK_W    = 3;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_REL = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_ABS = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;

    // one command as held in the input register
    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [CHANNEL_W-1:0] channel;
        logic [VALUE_W-1:0]   value;
    } cmct_cmd_t;

    // one response as held in the result register
    typedef struct packed {
        logic [MASK_W-1:0]  match_mask;
        logic [VALUE_W-1:0] counter_value;
    } cmct_rsp_t;

endpackage

`default_nettype wire

/* hdl/cmct_cmd_if.sv */
// command channel: valid/ready handshake with operation payload
`default_nettype none

interface cmct_cmd_if
    import cmct_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [CHANNEL_W-1:0] channel;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output opcode, output channel, output value, input ready);
    modport sink   (input valid, input opcode, input channel, input value, output ready);
endinterface

`default_nettype wire

/* hdl/cmct_rsp_if.sv */
// response channel: valid/ready handshake with mask and counter payload
`default_nettype none

interface cmct_rsp_if
    import cmct_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  match_mask;
    logic [VALUE_W-1:0] counter_value;

    modport source (output valid, output match_mask, output counter_value, input ready);
    modport sink   (input valid, input match_mask, input counter_value, output ready);
endinterface

`default_nettype wire

/* hdl/cmct_in_stage.sv */
// input register stage holding one command ahead of the execute stage
`default_nettype none

module cmct_in_stage
    import cmct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    cmct_cmd_if.sink      cmd,
    input  wire logic     take,
    output cmct_cmd_t     item,
    output logic          item_valid
);

    logic      valid_reg;
    logic      valid_next;
    cmct_cmd_t item_reg;
    logic      load;

    // accept when empty or when the held command moves on this cycle
    assign cmd.ready = !valid_reg || take;
    assign load      = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture on transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{opcode: cmd.opcode, channel: cmd.channel, value: cmd.value};
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

/* hdl/cmct_exec.sv */
// execute stage: timer state, compare logic and result register
`default_nettype none

module cmct_exec
    import cmct_pkg::*;
#(
    parameter int GRANULE_SHIFT = 10,
    parameter int CHANNEL_COUNT = 3
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmct_cmd_t item,
    input  wire logic      item_valid,
    output logic           take,
    cmct_rsp_if.source     rsp
);

    localparam logic [VALUE_W-1:0] GRANULE      = VALUE_W'(1) << GRANULE_SHIFT;
    localparam logic [VALUE_W-1:0] GRANULE_MASK = ~(GRANULE - VALUE_W'(1));

    logic [VALUE_W-1:0] tick_reg;
    logic [VALUE_W-1:0] tick_next;
    logic [VALUE_W-1:0] cmp_reg  [CHANNEL_COUNT];
    logic [VALUE_W-1:0] cmp_next [CHANNEL_COUNT];
    logic               out_valid_reg;
    logic               out_valid_next;
    cmct_rsp_t          rsp_reg;
    cmct_rsp_t          rsp_next;

    logic [VALUE_W-1:0]                rounded;
    logic [VALUE_W-1:0]                tick_step;
    logic [VALUE_W-1:0]                tick_after;
    logic                              hit0;
    logic [CHANNEL_COUNT+MASK_W-1:0]   hit_ext;

    // the held command moves on when the result register is free
    assign take    = item_valid && (!out_valid_reg || rsp.ready);
    assign rounded = item.value & GRANULE_MASK;

    // tick: advance, extra granule on channel 0 match, then compare the rest
    always_comb
    begin
        tick_step  = tick_reg + GRANULE;
        hit0       = (tick_step == cmp_reg[0]);
        tick_after = hit0 ? (tick_step + GRANULE) : tick_step;
        hit_ext    = '0;
        hit_ext[0] = hit0;
        for (int i = 1; i < CHANNEL_COUNT; i++)
        begin
            hit_ext[i] = (tick_after == cmp_reg[i]);
        end
    end

    // next state and response
    always_comb
    begin
        tick_next = tick_reg;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            cmp_next[i] = cmp_reg[i];
        end
        rsp_next = rsp_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next         = 1'b1;
            rsp_next.match_mask    = '0;
            rsp_next.counter_value = tick_reg;
            case (item.opcode)
                OP_TICK:
                begin
                    tick_next              = tick_after;
                    rsp_next.match_mask    = hit_ext[MASK_W-1:0];
                    rsp_next.counter_value = tick_after;
                end
                OP_SET_REL, OP_SET_ABS, OP_CLEAR:
                begin
                    for (int i = 0; i < CHANNEL_COUNT; i++)
                    begin
                        if (VALUE_W'(item.channel) == VALUE_W'(i))
                        begin
                            if (item.opcode == OP_SET_REL)
                            begin
                                cmp_next[i] = tick_reg + rounded;
                            end
                            else if (item.opcode == OP_SET_ABS)
                            begin
                                cmp_next[i] = rounded;
                            end
                            else
                            begin
                                cmp_next[i] = '0;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    rsp_next.match_mask = '0;
                end
                default:
                begin
                    rsp_next.match_mask = '0;
                end
            endcase
        end
    end

    // timer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= GRANULE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                cmp_reg[i] <= '0;
            end
        end
        else
        begin
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                cmp_reg[i] <= cmp_next[i];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.match_mask    = rsp_reg.match_mask;
    assign rsp.counter_value = rsp_reg.counter_value;

endmodule

`default_nettype wire

/* hdl/coarse_multi_channel_compare_timer_core.sv */
// Coarse compare timer: a 32-bit wrapping counter that advances by
// 2^GRANULE_SHIFT per tick and is compared against CHANNEL_COUNT compare
// registers. Each command on cmd (tick, set relative, set absolute, clear,
// read) produces exactly one response on rsp carrying the match mask (tick
// only) and the counter after the operation. Set values are rounded down to
// a granule; sets and clears to channels at or beyond CHANNEL_COUNT are
// ignored, and undefined opcodes behave as read. A match on channel 0 bumps
// the counter by one further granule before the other channels compare.
// One command is taken every cycle while rsp stays ready; the input register
// feeds a single execute stage that, once the result register is free,
// updates the timer state and loads the result register, from which the
// response is transferred. Both sides may stall freely.
`default_nettype none

module coarse_multi_channel_compare_timer_core
    import cmct_pkg::*;
#(
    parameter int GRANULE_SHIFT = 10,
    parameter int CHANNEL_COUNT = 3
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cmct_cmd_if.sink   cmd,
    cmct_rsp_if.source rsp
);

    cmct_cmd_t item;
    logic      item_valid;
    logic      take;

    // input register
    cmct_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    // execute and result register
    cmct_exec #(
        .GRANULE_SHIFT (GRANULE_SHIFT),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .take       (take),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
